### src/bqeq_pkg.sv
// shared constants and types for the biquad cascade equalizer
`default_nettype none

package bqeq_pkg;

    localparam int BANDS_DEF       = 10;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 32;

    // guard bits carried on signals between bands
    localparam int GUARD_BITS      = 8;
    // integer bits of a coefficient (Q8.x)
    localparam int COEF_INT_BITS   = 8;
    localparam int NUM_COEF        = 5;
    localparam int BAND_SEL_W      = 4;
    localparam int COEF_SEL_W      = 3;

    // item kind carried in tuser
    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    // coefficient selector codes
    localparam logic [COEF_SEL_W-1:0] COEF_B0 = 3'd0;
    localparam logic [COEF_SEL_W-1:0] COEF_B1 = 3'd1;
    localparam logic [COEF_SEL_W-1:0] COEF_B2 = 3'd2;
    localparam logic [COEF_SEL_W-1:0] COEF_A1 = 3'd3;
    localparam logic [COEF_SEL_W-1:0] COEF_A2 = 3'd4;

    typedef struct packed {
        logic                  en;
        logic [BAND_SEL_W-1:0] band;
        logic [COEF_SEL_W-1:0] sel;
    } coef_wr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cell_stat_t;

endpackage

`default_nettype wire

### src/bqeq_cell.sv
// one biquad section: coefficient registers, delay line and a shared multiply-accumulate
`default_nettype none

module bqeq_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = bqeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqeq_pkg::COEF_BITS_DEF
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             start,
    input  wire logic signed [SAMPLE_BITS+bqeq_pkg::GUARD_BITS-1:0] x_in,
    input  wire bqeq_pkg::coef_wr_t                               wr,
    input  wire logic signed [COEF_BITS-1:0]                      wr_value,
    output logic signed [SAMPLE_BITS+bqeq_pkg::GUARD_BITS-1:0]      y,
    output bqeq_pkg::cell_stat_t                                  stat
);
    import bqeq_pkg::*;

    localparam int SIG_W  = SAMPLE_BITS + GUARD_BITS;
    localparam int FRAC   = COEF_BITS - COEF_INT_BITS;
    localparam int PROD_W = COEF_BITS + SIG_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - FRAC;

    localparam logic [2:0] PH_LAST_MUL = 3'd4;
    localparam logic [2:0] PH_OUT      = 3'd6;

    logic signed [COEF_BITS-1:0] coef_reg [NUM_COEF];
    logic signed [SIG_W-1:0]     x_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic                        sub_reg;
    logic                        pv_reg;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic [2:0]                  ph_reg;
    logic                        busy_reg;

    logic signed [SIG_W-1:0]     op;
    logic signed [COEF_BITS-1:0] coef_rd;
    logic signed [ACC_W-1:0]     prod_ext;
    logic signed [ACC_W-1:0]     round_init;
    logic [SH_W-1:0]             shifted;
    logic [SH_W-SIG_W:0]         hi_bits;
    logic                        done;

    always_comb
    begin
        case (ph_reg)
            COEF_B0:
            begin
                op      = x_reg;
                coef_rd = coef_reg[0];
            end
            COEF_B1:
            begin
                op      = x1_reg;
                coef_rd = coef_reg[1];
            end
            COEF_B2:
            begin
                op      = x2_reg;
                coef_rd = coef_reg[2];
            end
            COEF_A1:
            begin
                op      = y1_reg;
                coef_rd = coef_reg[3];
            end
            default:
            begin
                op      = y2_reg;
                coef_rd = coef_reg[4];
            end
        endcase
    end

    assign prod_next  = coef_rd * op;
    assign prod_ext   = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next   = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
    // round half up before the arithmetic shift
    assign round_init = ACC_W'(1) << (FRAC - 1);

    assign shifted = acc_reg[ACC_W-1:FRAC];
    assign hi_bits = shifted[SH_W-1:SIG_W-1];

    always_comb
    begin
        if ((&hi_bits) || !(|hi_bits))
            y = shifted[SIG_W-1:0];
        else if (shifted[SH_W-1])
            y = {1'b1, {(SIG_W-1){1'b0}}};
        else
            y = {1'b0, {(SIG_W-1){1'b1}}};
    end

    assign done      = busy_reg && (ph_reg == PH_OUT);
    assign stat.busy = busy_reg;
    assign stat.done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 3'd0;
            pv_reg   <= 1'b0;
            x1_reg   <= '0;
            x2_reg   <= '0;
            y1_reg   <= '0;
            y2_reg   <= '0;
        end
        else
        begin
            pv_reg <= busy_reg && (ph_reg <= PH_LAST_MUL);
            if (start)
            begin
                busy_reg <= 1'b1;
                ph_reg   <= 3'd0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (done)
                begin
                    busy_reg <= 1'b0;
                    x1_reg   <= x_reg;
                    x2_reg   <= x1_reg;
                    y1_reg   <= y;
                    y2_reg   <= y1_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x_in;
            acc_reg <= round_init;
        end
        else if (pv_reg)
            acc_reg <= acc_next;
        prod_reg <= prod_next;
        // feedback terms are subtracted
        sub_reg  <= (ph_reg >= COEF_A1);
        if (wr.en && (32'(wr.band) == IDX) && (wr.sel <= COEF_A2))
            coef_reg[wr.sel] <= wr_value;
    end

endmodule

`default_nettype wire

### src/biquad_cascade_equalizer.sv
// top level: cascade of biquad cells with stream input and registered stream output
//
//  channel   dir  tdata                                          tuser
//  s_axis    in   sample_in, band_select, coef_select, coef_value mode
//  m_axis    out  sample_out                                     -
//
// a filter item runs through the cells one after another; each band does five products
// on the cell multiplier, the last accumulate, then round and saturate
// a coefficient write is taken on its transfer and gives no result
// reset clears the delay lines; coefficients are undefined until written
// input is held off while a sample is in the cascade or its result is queued
`default_nettype none

module biquad_cascade_equalizer #(
    parameter int BANDS       = bqeq_pkg::BANDS_DEF,
    parameter int SAMPLE_BITS = bqeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = bqeq_pkg::COEF_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // sample_in, band_select, coef_select, coef_value
    input  wire logic [((SAMPLE_BITS+bqeq_pkg::BAND_SEL_W+bqeq_pkg::COEF_SEL_W
                        +COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // sample_out
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import bqeq_pkg::*;

    localparam int SIG_W   = SAMPLE_BITS + GUARD_BITS;
    localparam int OUT_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int BAND_LO = SAMPLE_BITS;
    localparam int SEL_LO  = BAND_LO + BAND_SEL_W;
    localparam int CV_LO   = SEL_LO + COEF_SEL_W;

    logic                        in_xfer;
    logic                        fil_start;
    coef_wr_t                    wr;
    logic signed [COEF_BITS-1:0] wr_value;
    logic signed [SIG_W-1:0]     sig [BANDS+1];
    cell_stat_t                  stat [BANDS];
    logic [BANDS-1:0]            busy_vec;
    logic                        last_done;
    logic [SAMPLE_BITS-1:0]      final_sat;
    logic [SIG_W-SAMPLE_BITS:0]  final_hi;

    logic                        busy_reg;
    logic                        res_pend_reg;
    logic [SAMPLE_BITS-1:0]      res_data_reg;
    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      out_data_reg;
    logic                        move;

    assign s_axis_tready = !busy_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign fil_start     = in_xfer && (s_axis_tuser == MODE_FILTER);

    assign wr.en    = in_xfer && (s_axis_tuser == MODE_WRITE);
    assign wr.band  = s_axis_tdata[SEL_LO-1:BAND_LO];
    assign wr.sel   = s_axis_tdata[CV_LO-1:SEL_LO];
    assign wr_value = s_axis_tdata[CV_LO+COEF_BITS-1:CV_LO];

    assign sig[0] = {{GUARD_BITS{s_axis_tdata[SAMPLE_BITS-1]}},
                     s_axis_tdata[SAMPLE_BITS-1:0]};

    for (genvar k = 0; k < BANDS; k++)
    begin : g_cell
        bqeq_cell #(
            .IDX         (k),
            .SAMPLE_BITS (SAMPLE_BITS),
            .COEF_BITS   (COEF_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    ((k == 0) ? fil_start : stat[(k == 0) ? 0 : k-1].done),
            .x_in     (sig[k]),
            .wr       (wr),
            .wr_value (wr_value),
            .y        (sig[k+1]),
            .stat     (stat[k])
        );
        assign busy_vec[k] = stat[k].busy;
    end

    assign last_done = stat[BANDS-1].done;

    // clamp the guarded signal to the sample width
    assign final_hi = sig[BANDS][SIG_W-1:SAMPLE_BITS-1];
    always_comb
    begin
        if ((&final_hi) || !(|final_hi))
            final_sat = sig[BANDS][SAMPLE_BITS-1:0];
        else if (sig[BANDS][SIG_W-1])
            final_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            final_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end

    assign move = res_pend_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fil_start)
                busy_reg <= 1'b1;
            else if (move)
                busy_reg <= 1'b0;

            if (last_done)
                res_pend_reg <= 1'b1;
            else if (move)
                res_pend_reg <= 1'b0;

            if (move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_done)
            res_data_reg <= final_sat;
        if (move)
            out_data_reg <= res_data_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);

    // the cells of the cascade work strictly one at a time
    a_one_cell_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(busy_vec))
        else $error("more than one cell busy");

    // a result only finishes for a sample in flight with no result queued
    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        last_done |-> (busy_reg && !res_pend_reg))
        else $error("cascade result without a sample in flight");

    // a new output transfer is offered only from a queued result
    a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(res_pend_reg))
        else $error("output valid without a queued result");

    // no item is taken while a sample is in the cascade
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (|busy_vec) |-> !s_axis_tready)
        else $error("input ready while cascade busy");

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for the biquad cascade equalizer with a bit-exact predictor
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bqeq_pkg::*;

    localparam int SIG_W   = SAMPLE_BITS_DEF + GUARD_BITS;
    localparam int FRAC    = COEF_BITS_DEF - COEF_INT_BITS;
    localparam int UNITY   = 1 << FRAC;
    localparam int N_TAPS  = BANDS_DEF * NUM_COEF;
    localparam int N_HIST  = 2 * (BANDS_DEF + 1);

    typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
    typedef logic signed [SIG_W-1:0]           signal_t;
    typedef logic signed [COEF_BITS_DEF-1:0]   coef_t;
    // five exact products of 32x32 bits plus headroom
    typedef logic signed [79:0]                acc_t;

    class eq_tracker;
        coef_t   coef_mem [N_TAPS];
        signal_t hist [N_HIST];
        sample_t samples_due [$];
        int      errors;
        int      checked;
        int      filtered;
        int      written;
        int      ignored;

        function new();
            foreach (coef_mem[i])
            begin
                coef_mem[i] = '0;
            end
            foreach (hist[i])
            begin
                hist[i] = '0;
            end
            errors   = 0;
            checked  = 0;
            filtered = 0;
            written  = 0;
            ignored  = 0;
        endfunction

        function acc_t clamp(acc_t v, int bits);
            acc_t top;
            acc_t bottom;
            top    = (acc_t'(1) <<< (bits - 1)) - 1;
            bottom = -top - 1;
            if (v > top)
                return top;
            if (v < bottom)
                return bottom;
            return v;
        endfunction

        // one direct-form-I section: history of signal b is its input, of b+1 its output
        function signal_t band_section(int b, signal_t x);
            acc_t xs, x1, x2, y1, y2;
            acc_t b0, b1, b2, a1, a2;
            acc_t acc;
            xs  = x;
            x1  = hist[2*b];
            x2  = hist[2*b+1];
            y1  = hist[2*b+2];
            y2  = hist[2*b+3];
            b0  = coef_mem[b*NUM_COEF + COEF_B0];
            b1  = coef_mem[b*NUM_COEF + COEF_B1];
            b2  = coef_mem[b*NUM_COEF + COEF_B2];
            a1  = coef_mem[b*NUM_COEF + COEF_A1];
            a2  = coef_mem[b*NUM_COEF + COEF_A2];
            acc = b0*xs + b1*x1 + b2*x2 - a1*y1 - a2*y2;
            // round half up, then drop the coefficient fraction
            acc = acc + (acc_t'(1) <<< (FRAC - 1));
            acc = acc >>> FRAC;
            return signal_t'(clamp(acc, SIG_W));
        endfunction

        function void accept_item(logic mode, logic [SAMPLE_BITS_DEF-1:0] smp,
                                  logic [BAND_SEL_W-1:0] band, logic [COEF_SEL_W-1:0] sel,
                                  logic [COEF_BITS_DEF-1:0] val);
            signal_t sig [BANDS_DEF+1];
            if (mode == MODE_WRITE)
            begin
                if (band < BANDS_DEF && sel < NUM_COEF)
                begin
                    coef_mem[band*NUM_COEF + sel] = val;
                    written++;
                end
                else
                begin
                    ignored++;
                end
                return;
            end
            sig[0] = $signed(smp);
            for (int b = 0; b < BANDS_DEF; b++)
            begin
                sig[b+1] = band_section(b, sig[b]);
            end
            for (int k = 0; k <= BANDS_DEF; k++)
            begin
                hist[2*k+1] = hist[2*k];
                hist[2*k]   = sig[k];
            end
            samples_due.push_back(sample_t'(clamp(sig[BANDS_DEF], SAMPLE_BITS_DEF)));
            filtered++;
        endfunction

        task flag_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task compare_sample(logic [SAMPLE_BITS_DEF-1:0] got);
            sample_t want;
            if (samples_due.size() == 0)
            begin
                flag_mismatch($sformatf("sample %h arrived with none outstanding", got));
                return;
            end
            want = samples_due.pop_front();
            checked++;
            if (got !== want)
                flag_mismatch($sformatf("sample %0d: got %h, want %h", checked, got, want));
        endtask

        function int pending();
            return samples_due.size();
        endfunction
    endclass

    localparam int IN_W  = ((SAMPLE_BITS_DEF + BAND_SEL_W + COEF_SEL_W + COEF_BITS_DEF + 7)
                            / 8) * 8;
    localparam int OUT_W = ((SAMPLE_BITS_DEF + 7) / 8) * 8;

    localparam int TARGET_ITEMS   = 1950;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 600;

    localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS_DEF-1){1'b1}}};
    localparam logic [SAMPLE_BITS_DEF-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS_DEF-1){1'b0}}};

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    eq_tracker track;
    int        stim_count = 0;
    bit        tx_steady  = 1'b0;
    bit        rx_steady  = 1'b0;

    always #5 clk = ~clk;

    biquad_cascade_equalizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    task send_item(input logic mode, input logic [SAMPLE_BITS_DEF-1:0] smp,
                   input logic [BAND_SEL_W-1:0] band, input logic [COEF_SEL_W-1:0] sel,
                   input logic [COEF_BITS_DEF-1:0] val);
        int gap;
        if ($urandom_range(39) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(3);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= IN_W'({val, sel, band, smp});
        do
            @(posedge clk);
        while (!s_axis_tready);
        track.accept_item(mode, smp, band, sel, val);
        if (mode == MODE_FILTER || (band < BANDS_DEF && sel < NUM_COEF))
            stim_count++;
        @(negedge clk);
    endtask

    // fields a mode does not use carry random junk
    task send_sample(input logic [SAMPLE_BITS_DEF-1:0] smp);
        send_item(MODE_FILTER, smp, BAND_SEL_W'($urandom), COEF_SEL_W'($urandom), $urandom());
    endtask

    task write_coef(input logic [BAND_SEL_W-1:0] band, input logic [COEF_SEL_W-1:0] sel,
                    input logic [COEF_BITS_DEF-1:0] val);
        send_item(MODE_WRITE, SAMPLE_BITS_DEF'($urandom), band, sel, val);
    endtask

    function logic [SAMPLE_BITS_DEF-1:0] pick_sample();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return SAMPLE_BITS_DEF'($urandom);
        if (r < 9)
            return SAMPLE_BITS_DEF'(int'($urandom_range(1 << 17)) - (1 << 16));
        return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    endfunction

    function logic [COEF_BITS_DEF-1:0] near(int center, int span);
        return COEF_BITS_DEF'(center + int'($urandom_range(2 * span)) - span);
    endfunction

    // a full coefficient set for one band, some of them fully random
    task program_band(input int band);
        int                       style;
        logic [COEF_BITS_DEF-1:0] vals [NUM_COEF];
        style = $urandom_range(19);
        for (int s = 0; s < NUM_COEF; s++)
        begin
            if (style < 10)
                vals[s] = (s == COEF_B0) ? near(UNITY, UNITY / 4) : near(0, UNITY / 4);
            else if (style < 17)
            begin
                if (s == COEF_B0)
                    vals[s] = near(0, 2 * UNITY);
                else if (s == COEF_A1)
                    vals[s] = near(0, 3 * UNITY / 2);
                else if (s == COEF_A2)
                    vals[s] = near(0, 9 * UNITY / 10);
                else
                    vals[s] = near(0, UNITY);
            end
            else
                vals[s] = $urandom();
        end
        for (int s = 0; s < NUM_COEF; s++)
        begin
            write_coef(BAND_SEL_W'(band), COEF_SEL_W'(s), vals[s]);
        end
    endtask

    initial
    begin
        int burst;
        int pick;
        track = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every tap written first: flat cascade
        for (int b = 0; b < BANDS_DEF; b++)
        begin
            for (int s = 0; s < NUM_COEF; s++)
            begin
                write_coef(BAND_SEL_W'(b), COEF_SEL_W'(s), (s == COEF_B0) ? UNITY : 0);
            end
        end

        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample('1);
        // half gain: +1 rounds up to 1, -1 rounds up to 0
        write_coef(BAND_SEL_W'(0), COEF_B0, UNITY / 2);
        send_sample(SAMPLE_BITS_DEF'(1));
        send_sample('1);
        // writes with band or selector out of range must leave the store alone
        write_coef(BAND_SEL_W'(BANDS_DEF), COEF_B0, '0);
        write_coef('1, COEF_A2, $urandom());
        write_coef(BAND_SEL_W'(0), COEF_SEL_W'(NUM_COEF), '0);
        write_coef(BAND_SEL_W'(0), '1, $urandom());
        send_sample(SAMPLE_BITS_DEF'(3));
        // extreme gains on the last band drive the output saturation to both limits
        write_coef(BAND_SEL_W'(BANDS_DEF - 1), COEF_B0, 32'h7fff_ffff);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        write_coef(BAND_SEL_W'(BANDS_DEF - 1), COEF_B0, 32'h8000_0000);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_BITS_DEF'(1));
        write_coef(BAND_SEL_W'(BANDS_DEF - 1), COEF_B0, UNITY);
        write_coef(BAND_SEL_W'(0), COEF_B0, UNITY);
        // recursive band: impulse then silence shows the feedback terms
        write_coef(BAND_SEL_W'(3), COEF_B1, UNITY / 2);
        write_coef(BAND_SEL_W'(3), COEF_B2, -UNITY / 4);
        write_coef(BAND_SEL_W'(3), COEF_A1, -UNITY);
        write_coef(BAND_SEL_W'(3), COEF_A2, 3 * UNITY / 4);
        send_sample(SAMPLE_BITS_DEF'(1 << (SAMPLE_BITS_DEF - 2)));
        repeat (4) send_sample('0);

        while (stim_count < TARGET_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                program_band($urandom_range(BANDS_DEF - 1));
                burst = $urandom_range(60, 10);
            end
            else if (pick < 22)
            begin
                write_coef(BAND_SEL_W'($urandom), COEF_SEL_W'($urandom),
                           $urandom_range(1) ? $urandom() : near(0, 2 * UNITY));
                burst = 0;
            end
            else
                burst = $urandom_range(30, 1);
            repeat (burst) send_sample(pick_sample());
        end
        s_axis_tvalid <= 1'b0;

        while (track.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d filtered samples, %0d coefficient writes, %0d dropped writes",
                 track.filtered, track.written, track.ignored);
        $display("compared %0d output samples, with a %0d-cycle output stall",
                 track.checked, HOLD_CYCLES);
        if (track.errors == 0)
            $display("[biquad_cascade_equalizer] OK");
        else
            $display("[biquad_cascade_equalizer] ERROR");
        $finish;
    end

    // output side: random stalls, plus one long hold-off that backs up the input
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && track.checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if ($urandom_range(39) == 0)
                rx_steady = !rx_steady;
            gap = rx_steady ? 0 : $urandom_range(3);
            repeat (gap)
            begin
                m_axis_tready <= 1'b0;
                @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            track.compare_sample(m_axis_tdata[SAMPLE_BITS_DEF-1:0]);
            @(negedge clk);
        end
    end

    // ends the run when no transfer happens for too long
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("[biquad_cascade_equalizer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
